[rtl/transition_arc_executor_unit_assert.svh]
// ----------------------------------------------------------------------------
// transition arc executor assertion macros
// immediate-style wrappers around concurrent assertions, empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef TRANSITION_ARC_EXECUTOR_UNIT_ASSERT_SVH
`define TRANSITION_ARC_EXECUTOR_UNIT_ASSERT_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define TAEU_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TAEU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define TAEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TAEU_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define TAEU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TAEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/taeu_pkg.sv]
// ----------------------------------------------------------------------------
// taeu_pkg
// shared types, codes and defaults of the transition arc executor
// ----------------------------------------------------------------------------
`default_nettype none

package taeu_pkg;

    localparam int MAX_WORDS_DEF  = 128;
    localparam int LABEL_BITS_DEF = 8;

    localparam int LEN_W      = 8;
    localparam int LABEL_W    = 8;
    localparam int WORD_OUT_W = 7;
    localparam int ERR_W      = 2;
    localparam int KIND_W     = 2;

    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_ACTION = 1'b1;

    localparam logic [KIND_W-1:0] KIND_SHIFT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SWAP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY_BUFFER = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SHORT_STACK  = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [LEN_W-1:0]   sentence_length;
        logic [KIND_W-1:0]  action_kind;
        logic [LABEL_W-1:0] arc_label;
    } item_t;

    typedef struct packed {
        logic                  arc_made;
        logic [WORD_OUT_W-1:0] dependent_word;
        logic [WORD_OUT_W-1:0] head_word;
        logic [LABEL_W-1:0]    relation_label;
        logic [ERR_W-1:0]      error_code;
        logic                  finished;
    } result_t;

endpackage

`default_nettype wire

[rtl/taeu_ram.sv]
// ----------------------------------------------------------------------------
// taeu_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module taeu_ram #(
    parameter int DEPTH = taeu_pkg::MAX_WORDS_DEF,
    parameter int WIDTH = $clog2(taeu_pkg::MAX_WORDS_DEF)
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/taeu_core.sv]
// ----------------------------------------------------------------------------
// taeu_core
// stack and buffer state machine: top two stack words and the returned-word
// front are cached in registers, deeper entries are prefetched from ram
// ----------------------------------------------------------------------------
`default_nettype none
`include "transition_arc_executor_unit_assert.svh"

module taeu_core #(
    parameter int MAX_WORDS  = taeu_pkg::MAX_WORDS_DEF,
    parameter int LABEL_BITS = taeu_pkg::LABEL_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    input  wire taeu_pkg::item_t              item,
    input  wire logic                         hold,
    output logic                              take,
    output taeu_pkg::result_t                 take_result,
    output logic                              stk_wr_en,
    output logic [$clog2(MAX_WORDS)-1:0]      stk_wr_addr,
    output logic [$clog2(MAX_WORDS)-1:0]      stk_wr_data,
    output logic [$clog2(MAX_WORDS)-1:0]      stk_rd_addr,
    input  wire logic [$clog2(MAX_WORDS)-1:0] stk_rd_data,
    output logic                              ret_wr_en,
    output logic [$clog2(MAX_WORDS)-1:0]      ret_wr_addr,
    output logic [$clog2(MAX_WORDS)-1:0]      ret_wr_data,
    output logic [$clog2(MAX_WORDS)-1:0]      ret_rd_addr,
    input  wire logic [$clog2(MAX_WORDS)-1:0] ret_rd_data
);

    import taeu_pkg::*;

    localparam int AW         = $clog2(MAX_WORDS);
    localparam int CW         = $clog2(MAX_WORDS + 1);
    localparam int LABEL_KEEP = (LABEL_BITS >= LABEL_W) ? LABEL_W : LABEL_BITS;
    localparam logic [LABEL_W-1:0] LABEL_MASK = LABEL_W'((1 << LABEL_KEEP) - 1);

    logic [CW-1:0] stk_cnt_reg, stk_cnt_next;
    logic [CW-1:0] ret_cnt_reg, ret_cnt_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [CW-1:0] total_reg, total_next;
    logic [AW-1:0] top_reg, top_next;
    logic [AW-1:0] sec_reg, sec_next;
    logic [AW-1:0] ret_top_reg, ret_top_next;

    logic          buf_empty;
    logic [AW-1:0] front_word;
    logic [AW-1:0] head_w;
    logic [AW-1:0] dep_w;
    logic [CW-1:0] stk_below;
    logic [CW-1:0] stk_pref;
    logic [CW-1:0] ret_pref;

    assign take = item_valid && !hold;

    always_comb
    begin
        stk_cnt_next = stk_cnt_reg;
        ret_cnt_next = ret_cnt_reg;
        fresh_next   = fresh_reg;
        total_next   = total_reg;
        top_next     = top_reg;
        sec_next     = sec_reg;
        ret_top_next = ret_top_reg;
        stk_wr_en    = 1'b0;
        stk_wr_addr  = '0;
        stk_wr_data  = '0;
        ret_wr_en    = 1'b0;
        ret_wr_addr  = '0;
        ret_wr_data  = '0;
        take_result  = '0;
        head_w       = top_reg;
        dep_w        = sec_reg;

        buf_empty  = (ret_cnt_reg == '0) && (fresh_reg >= total_reg);
        front_word = (ret_cnt_reg != '0) ? ret_top_reg : fresh_reg[AW-1:0];
        stk_below  = stk_cnt_reg - CW'(2);

        if (take)
        begin
            if (item.mode == MODE_START)
            begin
                if (32'(item.sentence_length) > 32'(MAX_WORDS))
                begin
                    total_next = CW'(MAX_WORDS);
                end
                else
                begin
                    total_next = CW'(item.sentence_length);
                end
                stk_cnt_next = '0;
                ret_cnt_next = '0;
                fresh_next   = '0;
            end
            else if (item.action_kind == KIND_SHIFT)
            begin
                if (buf_empty)
                begin
                    take_result.error_code = ERR_EMPTY_BUFFER;
                end
                else
                begin
                    if (ret_cnt_reg != '0)
                    begin
                        ret_cnt_next = ret_cnt_reg - CW'(1);
                        ret_top_next = ret_rd_data;
                    end
                    else
                    begin
                        fresh_next = fresh_reg + CW'(1);
                    end
                    if (stk_cnt_reg < CW'(MAX_WORDS))
                    begin
                        stk_wr_en    = 1'b1;
                        stk_wr_addr  = stk_cnt_reg[AW-1:0];
                        stk_wr_data  = front_word;
                        stk_cnt_next = stk_cnt_reg + CW'(1);
                        top_next     = front_word;
                        sec_next     = top_reg;
                    end
                end
            end
            else if (stk_cnt_reg < CW'(2))
            begin
                take_result.error_code = ERR_SHORT_STACK;
            end
            else
            begin
                // pop two, push one: new second word comes from the prefetch
                stk_cnt_next = stk_cnt_reg - CW'(1);
                sec_next     = stk_rd_data;
                stk_wr_en    = 1'b1;
                stk_wr_addr  = stk_below[AW-1:0];
                if (item.action_kind == KIND_SWAP)
                begin
                    stk_wr_data = top_reg;
                    if (ret_cnt_reg < CW'(MAX_WORDS))
                    begin
                        ret_wr_en    = 1'b1;
                        ret_wr_addr  = ret_cnt_reg[AW-1:0];
                        ret_wr_data  = sec_reg;
                        ret_cnt_next = ret_cnt_reg + CW'(1);
                        ret_top_next = sec_reg;
                    end
                end
                else
                begin
                    if (item.action_kind == KIND_LEFT)
                    begin
                        head_w = top_reg;
                        dep_w  = sec_reg;
                    end
                    else
                    begin
                        head_w = sec_reg;
                        dep_w  = top_reg;
                    end
                    top_next                   = head_w;
                    stk_wr_data                = head_w;
                    take_result.arc_made       = 1'b1;
                    take_result.dependent_word = WORD_OUT_W'(dep_w);
                    take_result.head_word      = WORD_OUT_W'(head_w);
                    take_result.relation_label = item.arc_label & LABEL_MASK;
                end
            end
        end

        take_result.finished = (ret_cnt_next == '0) && (fresh_next >= total_next)
                               && (stk_cnt_next == CW'(1));

        // prefetch third stack word and second returned word of the next state
        stk_pref    = stk_cnt_next - CW'(3);
        ret_pref    = ret_cnt_next - CW'(2);
        stk_rd_addr = stk_pref[AW-1:0];
        ret_rd_addr = ret_pref[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stk_cnt_reg <= '0;
            ret_cnt_reg <= '0;
            fresh_reg   <= '0;
            total_reg   <= '0;
        end
        else
        begin
            stk_cnt_reg <= stk_cnt_next;
            ret_cnt_reg <= ret_cnt_next;
            fresh_reg   <= fresh_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        sec_reg     <= sec_next;
        ret_top_reg <= ret_top_next;
    end

    `TAEU_ASSERT_NEXT(a_start_clears, clk, rst_n, take && (item.mode == MODE_START), (stk_cnt_reg == '0) && (ret_cnt_reg == '0) && (fresh_reg == '0), "start did not empty stack and buffer")
    `TAEU_ASSERT_ALWAYS(a_count_bound, clk, rst_n, (stk_cnt_reg <= CW'(MAX_WORDS)) && (ret_cnt_reg <= CW'(MAX_WORDS)) && (total_reg <= CW'(MAX_WORDS)), "count beyond capacity")
    `TAEU_ASSERT_IMPL(a_arc_needs_two, clk, rst_n, take && take_result.arc_made, (stk_cnt_reg >= CW'(2)) && (take_result.error_code == ERR_NONE), "arc made from short stack")

endmodule

`default_nettype wire

[rtl/taeu_out_fifo.sv]
// ----------------------------------------------------------------------------
// taeu_out_fifo
// two-entry result queue; stall toward the input depends only on its fill
// ----------------------------------------------------------------------------
`default_nettype none
`include "transition_arc_executor_unit_assert.svh"

module taeu_out_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire taeu_pkg::result_t push_data,
    output logic                   full,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output taeu_pkg::result_t      result
);

    import taeu_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic       pop;

    assign full         = (cnt_reg == 2'd2);
    assign result_valid = (cnt_reg != 2'd0);
    assign result       = head_reg;
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (pop && push)
        begin
            if (cnt_reg == 2'd1)
            begin
                head_next = push_data;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end
        else if (pop)
        begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_next = push_data;
            end
            else
            begin
                tail_next = push_data;
            end
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    `TAEU_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, cnt_reg != 2'd2, "transfer into full result queue")
    `TAEU_ASSERT_ALWAYS(a_fill_range, clk, rst_n, cnt_reg != 2'd3, "result queue fill out of range")

endmodule

`default_nettype wire

[rtl/transition_arc_executor_unit.sv]
// ----------------------------------------------------------------------------
// transition_arc_executor_unit
// executes arc-standard transitions with swap over a ram-backed stack and
// a ram-backed buffer of returned words
//
//   channel  | dir | handshake                  | payload
//   item     | in  | item_valid / item_stall    | taeu_pkg::item_t
//   result   | out | result_valid / result_stall | taeu_pkg::result_t
//
// one item per cycle sustained while item_stall is low; each result is registered in the queue
// the rate rests on the registered ram prefetch of the third stack word and
// the second returned word, issued from the next-state counts every cycle
// item_stall rises only when two results wait in the output queue
// reset clears the counts only; ram contents need no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module transition_arc_executor_unit #(
    parameter int MAX_WORDS  = taeu_pkg::MAX_WORDS_DEF,
    parameter int LABEL_BITS = taeu_pkg::LABEL_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire taeu_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output taeu_pkg::result_t      result
);

    import taeu_pkg::*;

    localparam int AW = $clog2(MAX_WORDS);

    logic          take;
    result_t       take_result;
    logic          full;
    logic          stk_wr_en;
    logic [AW-1:0] stk_wr_addr;
    logic [AW-1:0] stk_wr_data;
    logic [AW-1:0] stk_rd_addr;
    logic [AW-1:0] stk_rd_data;
    logic          ret_wr_en;
    logic [AW-1:0] ret_wr_addr;
    logic [AW-1:0] ret_wr_data;
    logic [AW-1:0] ret_rd_addr;
    logic [AW-1:0] ret_rd_data;

    assign item_stall = full;

    taeu_core #(
        .MAX_WORDS  (MAX_WORDS),
        .LABEL_BITS (LABEL_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .hold        (full),
        .take        (take),
        .take_result (take_result),
        .stk_wr_en   (stk_wr_en),
        .stk_wr_addr (stk_wr_addr),
        .stk_wr_data (stk_wr_data),
        .stk_rd_addr (stk_rd_addr),
        .stk_rd_data (stk_rd_data),
        .ret_wr_en   (ret_wr_en),
        .ret_wr_addr (ret_wr_addr),
        .ret_wr_data (ret_wr_data),
        .ret_rd_addr (ret_rd_addr),
        .ret_rd_data (ret_rd_data)
    );

    taeu_ram #(
        .DEPTH (MAX_WORDS),
        .WIDTH (AW)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    taeu_ram #(
        .DEPTH (MAX_WORDS),
        .WIDTH (AW)
    ) u_returned_ram (
        .clk     (clk),
        .wr_en   (ret_wr_en),
        .wr_addr (ret_wr_addr),
        .wr_data (ret_wr_data),
        .rd_addr (ret_rd_addr),
        .rd_data (ret_rd_data)
    );

    taeu_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (take),
        .push_data    (take_result),
        .full         (full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
